[hw/rtl/bms_pkg.sv]
// shared widths, types and the controller-to-datapath command and status words
// for the merge sort block; no dependencies
`timescale 1ns / 1ps

package bms_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CNT_W:0]    sum_t;

	typedef struct packed {
		logic store;   // input word accepted
		logic start;   // accepted word closes the set
		logic prime;   // set up a pass, fetch the first heads
		logic merge;   // one merge step
		logic drain;   // output phase
		logic emit;    // output word taken
	} cmd_t;

	typedef struct packed {
		logic pass_last;
		logic sort_done;
		logic out_last;
	} status_t;

	function automatic sum_t umin(input sum_t a, input sum_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

[hw/rtl/bms_ctrl.sv]
// state machine of the merge sort: load, pass setup, merge, output
// depends on bms_pkg
`timescale 1ns / 1ps

module bms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  bms_pkg::status_t status,
	output bms_pkg::cmd_t    cmd
);
	import bms_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_PRIME = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
				cmd.start = in_valid & in_last;
				if (in_valid && in_last) state_d = ST_PRIME;
			end
			ST_PRIME: begin
				cmd.prime = 1'b1;
				state_d = status.sort_done ? ST_OUT : ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				if (status.pass_last) state_d = ST_PRIME;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.drain = 1'b1;
				cmd.emit  = out_ready;
				if (out_ready && status.out_last) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

[hw/rtl/bms_datapath.sv]
// two word buffers with two registered read ports each, run pointers and the
// compare-select merge step; depends on bms_pkg
`timescale 1ns / 1ps

module bms_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bms_pkg::cmd_t     cmd,
	input  bms_pkg::data_t    in_data,
	output bms_pkg::data_t    out_data,
	output bms_pkg::status_t  status
);
	import bms_pkg::*;

	data_t mem_a [MAX_ITEMS];
	data_t mem_b [MAX_ITEMS];
	data_t a_p_q, a_q_q, b_p_q, b_q_q;

	cnt_t  cnt_q, len_q, p_q, q_q, mid_q, end_q, o_q;
	logic  src_b_q;

	cnt_t  p_d, q_d, mid_d, end_d, o_d, o_inc;
	idx_t  ra_p, ra_q;
	data_t hp, hq, wdata;
	logic  p_ex, q_ex, take_p, pair_last, room;
	logic  a_we, b_we;
	idx_t  a_waddr;
	data_t a_wdata;

	always_comb begin
		hp        = src_b_q ? b_p_q : a_p_q;
		hq        = src_b_q ? b_q_q : a_q_q;
		p_ex      = (p_q == mid_q);
		q_ex      = (q_q == end_q);
		take_p    = !p_ex && (q_ex || ($signed(hp) < $signed(hq)));
		wdata     = take_p ? hp : hq;
		o_inc     = o_q + cnt_t'(1);
		pair_last = (o_inc == end_q);
		room      = (cnt_q < cnt_t'(MAX_ITEMS));

		p_d   = p_q;
		q_d   = q_q;
		mid_d = mid_q;
		end_d = end_q;
		o_d   = o_q;
		if (cmd.prime) begin
			p_d   = '0;
			mid_d = cnt_t'(umin(sum_t'(len_q), sum_t'(cnt_q)));
			q_d   = mid_d;
			end_d = cnt_t'(umin(sum_t'(len_q) << 1, sum_t'(cnt_q)));
			o_d   = '0;
		end else if (cmd.merge) begin
			o_d = o_inc;
			if (pair_last) begin
				// next pair of runs starts where this one ended
				p_d   = end_q;
				mid_d = cnt_t'(umin(sum_t'(end_q) + sum_t'(len_q), sum_t'(cnt_q)));
				q_d   = mid_d;
				end_d = cnt_t'(umin(sum_t'(end_q) + (sum_t'(len_q) << 1),
					sum_t'(cnt_q)));
			end else begin
				p_d = p_q + cnt_t'(take_p);
				q_d = q_q + cnt_t'(!take_p);
			end
		end else if (cmd.emit) begin
			o_d = o_inc;
		end

		// read addresses follow the next pointers so the heads are always current
		ra_p = p_d[IDX_W-1:0];
		ra_q = q_d[IDX_W-1:0];
		if (cmd.drain) ra_p = o_d[IDX_W-1:0];

		a_we    = (cmd.store && room) || (cmd.merge && src_b_q);
		a_waddr = cmd.store ? cnt_q[IDX_W-1:0] : o_q[IDX_W-1:0];
		a_wdata = cmd.store ? in_data : wdata;
		b_we    = cmd.merge && !src_b_q;
	end

	always_ff @(posedge clk) begin
		if (a_we) mem_a[a_waddr] <= a_wdata;
		if (b_we) mem_b[o_q[IDX_W-1:0]] <= wdata;
		a_p_q <= mem_a[ra_p];
		a_q_q <= mem_a[ra_q];
		b_p_q <= mem_b[ra_p];
		b_q_q <= mem_b[ra_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			len_q   <= cnt_t'(1);
			src_b_q <= 1'b0;
			p_q     <= '0;
			q_q     <= '0;
			mid_q   <= '0;
			end_q   <= '0;
			o_q     <= '0;
		end else begin
			p_q   <= p_d;
			q_q   <= q_d;
			mid_q <= mid_d;
			end_q <= end_d;
			o_q   <= o_d;
			if (cmd.store && room) cnt_q <= cnt_q + cnt_t'(1);
			else if (cmd.emit && status.out_last) cnt_q <= '0;
			if (cmd.start) begin
				len_q   <= cnt_t'(1);
				src_b_q <= 1'b0;
			end else if (cmd.merge && status.pass_last) begin
				len_q   <= len_q << 1;
				src_b_q <= !src_b_q;
			end
		end
	end

	assign status.pass_last = pair_last && (end_q == cnt_q);
	assign status.sort_done = (len_q >= cnt_q);
	assign status.out_last  = (o_inc == cnt_q);
	assign out_data         = hp;

endmodule

[hw/rtl/bottom_up_merge_sort.sv]
// Sorts a set of up to 64 signed 32-bit words into ascending order. Words enter one per
// cycle on the slave side; the word with tlast closes the set (words past the 64th are
// dropped, but their tlast still closes it). The set is then sorted by bottom-up two-way
// merge passes, run length 1, 2, 4 and so on, ping-ponging between two buffers; on equal
// keys the word of the later run goes first. Each pass has a setup step to fetch the run
// heads, then one merge step per word, and there are ceil(log2 n) passes. The sorted
// words then leave one per cycle while m_axis_tready is high on the master side, tlast
// on the greatest. No input is taken from the closing word until the last sorted word
// has been taken.
// depends on bms_pkg, bms_ctrl, bms_datapath
`timescale 1ns / 1ps

module bottom_up_merge_sort (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [bms_pkg::IN_W-1:0]  s_axis_tdata,   // value
	input  logic                      s_axis_tlast,   // final_value
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [bms_pkg::OUT_W-1:0] m_axis_tdata,   // sorted_value
	output logic                      m_axis_tlast    // last_out
);
	import bms_pkg::*;

	cmd_t    cmd;
	status_t status;
	data_t   out_data;

	bms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.status    (status),
		.cmd       (cmd)
	);

	bms_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (DATA_W'(s_axis_tdata)),
		.out_data (out_data),
		.status   (status)
	);

	assign m_axis_tdata = OUT_W'(out_data);
	assign m_axis_tlast = status.out_last;

endmodule

[tb/sv/bottom_up_merge_sort_tb.sv]
// testbench for bottom_up_merge_sort: streams sets of signed words in, predicts the
// sorted output of each closed set and checks every master-side word against it
// depends on bms_pkg and bottom_up_merge_sort
`timescale 1ns / 1ps

module bottom_up_merge_sort_tb;

	import bms_pkg::*;

	typedef struct {
		logic [IN_W-1:0] value;
		logic            closes;  // word carries tlast
		logic            hold;    // wait for every sorted word before sending
		logic            calm;    // no idling on either side while this is out
	} in_word_t;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             last;
	} sorted_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [IN_W-1:0]           s_axis_tdata;
	logic                      s_axis_tlast;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [OUT_W-1:0]          m_axis_tdata;
	logic                      m_axis_tlast;

	in_word_t                  send_queue[$];
	sorted_word_t              sorted_expect[$];
	logic signed [DATA_W-1:0]  set_words[MAX_ITEMS];
	int                        set_count;
	int                        errors;
	int                        words_queued;
	logic                      in_taken;
	logic                      calm;

	bottom_up_merge_sort u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// collect a word into the current set; a closing word sorts the set and
	// queues its words in ascending order, words past the buffer size are dropped
	task automatic collect_word(input logic [IN_W-1:0] w, input logic closes);
		logic signed [DATA_W-1:0] ord[MAX_ITEMS];
		logic signed [DATA_W-1:0] key;
		sorted_word_t             e;
		int                       j;
		if (set_count < MAX_ITEMS) begin
			set_words[set_count] = $signed(w);
			set_count++;
		end
		if (closes) begin
			for (int i = 0; i < set_count; i++)
				ord[i] = set_words[i];
			for (int i = 1; i < set_count; i++) begin
				key = ord[i];
				j = i - 1;
				while (j >= 0 && ord[j] > key) begin
					ord[j + 1] = ord[j];
					j--;
				end
				ord[j + 1] = key;
			end
			for (int i = 0; i < set_count; i++) begin
				e.value = ord[i];
				e.last  = (i == set_count - 1);
				sorted_expect.push_back(e);
			end
			set_count = 0;
		end
	endtask

	task automatic queue_word(input logic [IN_W-1:0] v, input logic closes,
			input logic hold, input logic quiet);
		in_word_t w;
		w.value  = v;
		w.closes = closes;
		w.hold   = hold;
		w.calm   = quiet;
		send_queue.push_back(w);
		words_queued++;
	endtask

	// style 0: full range, 1: narrow range with many repeats, 2: extremes mixed in
	task automatic queue_set(input int n, input int style, input logic hold,
			input logic quiet);
		logic [IN_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			case (style)
				1: v = $urandom_range(15) - 8;
				2: begin
					case ($urandom_range(4))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'hffff_ffff;
						3: v = '0;
						default: v = $urandom;
					endcase
				end
				default: v = $urandom;
			endcase
			queue_word(v, i == n - 1, hold && i == 0, quiet);
		end
	endtask

	// driver: a new word only once the previous one was taken
	always @(negedge clk) begin
		in_word_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (send_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (send_queue[0].hold && sorted_expect.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(99) < 32) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				w = send_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= w.value;
				s_axis_tlast  <= w.closes;
				calm          <= w.calm;
			end
		end
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
	end

	// monitor: predict on every accepted input word, check every output word
	always @(posedge clk) begin
		sorted_word_t e;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				collect_word(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					e = sorted_expect.pop_front();
					if (m_axis_tdata !== e.value || m_axis_tlast !== e.last) begin
						$display("%0t: sorted word mismatch, expected %h last %b, got %h last %b",
							$time, e.value, e.last, m_axis_tdata, m_axis_tlast);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		in_taken      = 1'b0;
		calm          = 1'b0;
		set_count     = 0;
		errors        = 0;
		words_queued  = 0;

		// directed sets: single word, extremes, repeats, all equal, descending
		queue_word(32'd5, 1'b1, 1'b1, 1'b0);
		queue_word(32'h7fff_ffff, 1'b0, 1'b0, 1'b0);
		queue_word(32'h8000_0000, 1'b1, 1'b0, 1'b0);
		queue_word(32'h0000_0000, 1'b0, 1'b0, 1'b0);
		queue_word(32'hffff_ffff, 1'b0, 1'b0, 1'b0);
		queue_word(32'h0000_0001, 1'b0, 1'b0, 1'b0);
		queue_word(32'h8000_0000, 1'b0, 1'b0, 1'b0);
		queue_word(32'h7fff_ffff, 1'b0, 1'b0, 1'b0);
		queue_word(32'h0000_0000, 1'b0, 1'b0, 1'b0);
		queue_word(32'hffff_ffff, 1'b1, 1'b0, 1'b0);
		queue_word(32'd3, 1'b0, 1'b0, 1'b0);
		queue_word(32'd3, 1'b0, 1'b0, 1'b0);
		queue_word(32'd3, 1'b1, 1'b0, 1'b0);
		queue_word(32'd4, 1'b0, 1'b0, 1'b0);
		queue_word(32'd3, 1'b0, 1'b0, 1'b0);
		queue_word(32'd2, 1'b0, 1'b0, 1'b0);
		queue_word(32'hffff_fffe, 1'b1, 1'b0, 1'b0);

		// a full buffer and a short set of extremes with no idling, then an overfull set closed by a dropped word
		queue_set(MAX_ITEMS, 0, 1'b1, 1'b1);
		queue_set(3, 2, 1'b0, 1'b1);
		queue_set(MAX_ITEMS + 3, 1, 1'b0, 1'b0);

		for (int k = 0; words_queued < 180; k++)
			queue_set($urandom_range(1, 12), $urandom_range(2), (k % 5) == 4, 1'b0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (send_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (sorted_expect.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
